// ===== rtl/npk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package npk_pkg;

   localparam int COORD_W        = 24;
   localparam int DIST_W         = 49;
   localparam int IMAGE_W        = 8;
   localparam int SOUND_W        = 16;
   localparam int SLOT_W         = 6;
   localparam int FILL_W         = 7;
   localparam int CSR_IDX_W      = 1;
   localparam int ENTRY_W        = 2 * COORD_W + DIST_W + IMAGE_W + SOUND_W + 1;
   localparam int MAX_POINTS_DEF = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 1'd1;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   typedef struct packed {
      logic capture;
      logic append;
      logic replace;
      logic scan_step;
      logic load_rsp;
   } npk_cmd_type;

   typedef struct packed {
      logic op_read;
      logic room;
      logic nearer;
      logic scan_done;
   } npk_status_type;

endpackage
`default_nettype wire

// ===== rtl/nearest_point_keeper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Nearest point keeper: holds up to MAX_POINTS map points nearest a center.
// Command channel: a transfer happens at a clock edge with start high and
// busy low; req_op selects insert (point, tags, route flag) or slot read.
// Result channel: one result per command, shown for exactly one cycle while
// rsp_valid is high; the receiver cannot stall it, so it must take it then.
// Config: csr_we writes csr_wdata to center x (index 0) or center y (index 1)
// at once; write only while busy is low.
// Steps from start transfer to result transfer:
//   read: table RAM read, then result load
//   insert appended or rejected: abs diff, square, add, decide
//   insert that replaces the farthest entry: the same steps, then a
//   rescan of every slot, one stored distance per cycle from the table RAM.
// One command at a time; busy drops in the cycle rsp_valid is high, so the
// next command can be transferred in that cycle.
// Reset clears the fill count, the farthest entry and the center; table
// contents are only valid below the fill count.
module nearest_point_keeper
   import npk_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_op,
   input  wire logic [COORD_W-1:0]   req_point_x,
   input  wire logic [COORD_W-1:0]   req_point_y,
   input  wire logic [IMAGE_W-1:0]   req_image_tag,
   input  wire logic [SOUND_W-1:0]   req_sound_tag,
   input  wire logic                 req_route_flag,
   input  wire logic [SLOT_W-1:0]    req_read_slot,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COORD_W-1:0]   csr_wdata,
   output logic                      rsp_valid,
   output logic                      rsp_accepted,
   output logic [SLOT_W-1:0]         rsp_written_slot,
   output logic [FILL_W-1:0]         rsp_fill_count,
   output logic [SLOT_W-1:0]         rsp_farthest_slot,
   output logic [COORD_W-1:0]        rsp_out_x,
   output logic [COORD_W-1:0]        rsp_out_y,
   output logic [DIST_W-1:0]         rsp_out_dist_sq,
   output logic [IMAGE_W-1:0]        rsp_out_image,
   output logic [SOUND_W-1:0]        rsp_out_sound,
   output logic                      rsp_out_route
);

   npk_cmd_type    cmd;
   npk_status_type status;

   npk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   npk_datapath #(
      .MAX_POINTS (MAX_POINTS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_op            (req_op),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_image_tag     (req_image_tag),
      .req_sound_tag     (req_sound_tag),
      .req_route_flag    (req_route_flag),
      .req_read_slot     (req_read_slot),
      .rsp_accepted      (rsp_accepted),
      .rsp_written_slot  (rsp_written_slot),
      .rsp_fill_count    (rsp_fill_count),
      .rsp_farthest_slot (rsp_farthest_slot),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_dist_sq   (rsp_out_dist_sq),
      .rsp_out_image     (rsp_out_image),
      .rsp_out_sound     (rsp_out_sound),
      .rsp_out_route     (rsp_out_route)
   );

`ifndef ASSERT_OFF
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("command transfer did not start work");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.append, cmd.replace, cmd.scan_step, cmd.load_rsp}))
      else $error("conflicting datapath commands");
`endif

endmodule
`default_nettype wire

// ===== rtl/npk_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module npk_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/npk_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module npk_ctrl
   import npk_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   output logic                busy,
   output logic                rsp_valid,
   input  wire npk_status_type status,
   output npk_cmd_type         cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DIST1   = 3'd1;
   localparam logic [2:0] ST_DIST2   = 3'd2;
   localparam logic [2:0] ST_DIST3   = 3'd3;
   localparam logic [2:0] ST_DECIDE  = 3'd4;
   localparam logic [2:0] ST_SCAN    = 3'd5;
   localparam logic [2:0] ST_RD_WAIT = 3'd6;
   localparam logic [2:0] ST_RESP    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DIST1;
            end
         end
         ST_DIST1: begin
            state_in = status.op_read ? ST_RD_WAIT : ST_DIST2;
         end
         ST_DIST2: begin
            state_in = ST_DIST3;
         end
         ST_DIST3: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.room) begin
               cmd.append = 1'b1;
               state_in   = ST_RESP;
            end else if (status.nearer) begin
               cmd.replace = 1'b1;
               state_in    = ST_SCAN;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RD_WAIT: begin
            cmd.load_rsp = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_RESP: begin
            cmd.load_rsp = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.load_rsp;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/npk_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module npk_datapath
   import npk_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire npk_cmd_type          cmd,
   output npk_status_type            status,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COORD_W-1:0]   csr_wdata,
   input  wire logic                 req_op,
   input  wire logic [COORD_W-1:0]   req_point_x,
   input  wire logic [COORD_W-1:0]   req_point_y,
   input  wire logic [IMAGE_W-1:0]   req_image_tag,
   input  wire logic [SOUND_W-1:0]   req_sound_tag,
   input  wire logic                 req_route_flag,
   input  wire logic [SLOT_W-1:0]    req_read_slot,
   output logic                      rsp_accepted,
   output logic [SLOT_W-1:0]         rsp_written_slot,
   output logic [FILL_W-1:0]         rsp_fill_count,
   output logic [SLOT_W-1:0]         rsp_farthest_slot,
   output logic [COORD_W-1:0]        rsp_out_x,
   output logic [COORD_W-1:0]        rsp_out_y,
   output logic [DIST_W-1:0]         rsp_out_dist_sq,
   output logic [IMAGE_W-1:0]        rsp_out_image,
   output logic [SOUND_W-1:0]        rsp_out_sound,
   output logic                      rsp_out_route
);

   localparam int AW    = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int EXT_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam int SQ_W  = 2 * COORD_W;

   // center
   logic [COORD_W-1:0] center_x_ff, center_y_ff;

   // captured item
   logic               op_ff;
   logic [COORD_W-1:0] px_ff, py_ff;
   logic [IMAGE_W-1:0] image_ff;
   logic [SOUND_W-1:0] sound_ff;
   logic               route_ff;
   logic [AW-1:0]      slot_addr_ff;
   logic               rd_hit_ff, rd_hit_in;

   // distance pipeline
   logic [COORD_W-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic [SQ_W-1:0]    sqx_ff, sqy_ff;
   logic [DIST_W-1:0]  dist_ff, dist_in;

   // table state
   logic [CNT_W-1:0]   occupied_ff;
   logic [DIST_W-1:0]  largest_dist_ff;
   logic [AW-1:0]      largest_slot_ff;
   logic [CNT_W-1:0]   scan_ff;
   logic [CNT_W-1:0]   scan_prev;
   logic               accepted_ff;
   logic [AW-1:0]      wslot_ff;

   // memory
   logic               mem_we;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
   logic [DIST_W-1:0]  rd_dist;

   // response registers
   logic               rsp_accepted_ff;
   logic [SLOT_W-1:0]  rsp_wslot_ff, rsp_far_ff;
   logic [FILL_W-1:0]  rsp_fill_ff;
   logic [ENTRY_W-1:0] rsp_entry_ff;

   logic [EXT_W-1:0]   slot_ext, occ_ext, max_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign slot_ext  = EXT_W'(req_read_slot);
   assign occ_ext   = EXT_W'(occupied_ff);
   assign max_ext   = EXT_W'(MAX_POINTS);
   assign rd_hit_in = (slot_ext < occ_ext) && (slot_ext < max_ext);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= req_op;
         px_ff        <= req_point_x;
         py_ff        <= req_point_y;
         image_ff     <= req_image_tag;
         sound_ff     <= req_sound_tag;
         route_ff     <= req_route_flag;
         slot_addr_ff <= AW'(slot_ext);
         rd_hit_ff    <= rd_hit_in;
      end
   end

   assign dx_in   = (px_ff >= center_x_ff) ? px_ff - center_x_ff : center_x_ff - px_ff;
   assign dy_in   = (py_ff >= center_y_ff) ? py_ff - center_y_ff : center_y_ff - py_ff;
   assign dist_in = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      sqx_ff  <= dx_ff * dx_ff;
      sqy_ff  <= dy_ff * dy_ff;
      dist_ff <= dist_in;
   end

   assign scan_prev = scan_ff - CNT_W'(1);
   assign rd_dist   = mem_rdata[ENTRY_W-2*COORD_W-1 -: DIST_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         occupied_ff     <= '0;
         largest_dist_ff <= '0;
         largest_slot_ff <= '0;
      end else if (cmd.append) begin
         occupied_ff <= occupied_ff + CNT_W'(1);
         if (dist_ff > largest_dist_ff) begin
            largest_dist_ff <= dist_ff;
            largest_slot_ff <= occupied_ff[AW-1:0];
         end
      end else if (cmd.replace) begin
         largest_dist_ff <= '0;
      end else if (cmd.scan_step && scan_ff != '0) begin
         if (rd_dist > largest_dist_ff) begin
            largest_dist_ff <= rd_dist;
            largest_slot_ff <= scan_prev[AW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.replace) begin
         scan_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         accepted_ff <= 1'b0;
         wslot_ff    <= '0;
      end else if (cmd.append) begin
         accepted_ff <= 1'b1;
         wslot_ff    <= occupied_ff[AW-1:0];
      end else if (cmd.replace) begin
         accepted_ff <= 1'b1;
         wslot_ff    <= largest_slot_ff;
      end
   end

   assign mem_we    = cmd.append | cmd.replace;
   assign mem_waddr = cmd.append ? occupied_ff[AW-1:0] : largest_slot_ff;
   assign mem_wdata = {px_ff, py_ff, dist_ff, image_ff, sound_ff, route_ff};
   assign mem_raddr = (op_ff == OP_READ) ? slot_addr_ff : scan_ff[AW-1:0];

   npk_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_POINTS)
   ) u_table (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_accepted_ff <= accepted_ff;
         rsp_wslot_ff    <= SLOT_W'(wslot_ff);
         rsp_fill_ff     <= FILL_W'(occupied_ff);
         rsp_far_ff      <= SLOT_W'(largest_slot_ff);
         rsp_entry_ff    <= ((op_ff == OP_READ) && rd_hit_ff) ? mem_rdata : '0;
      end
   end

   assign status.op_read   = (op_ff == OP_READ);
   assign status.room      = occupied_ff < CNT_W'(MAX_POINTS);
   assign status.nearer    = dist_ff < largest_dist_ff;
   assign status.scan_done = scan_ff == CNT_W'(MAX_POINTS);

   assign rsp_accepted      = rsp_accepted_ff;
   assign rsp_written_slot  = rsp_wslot_ff;
   assign rsp_fill_count    = rsp_fill_ff;
   assign rsp_farthest_slot = rsp_far_ff;
   assign {rsp_out_x, rsp_out_y, rsp_out_dist_sq, rsp_out_image, rsp_out_sound,
           rsp_out_route} = rsp_entry_ff;

endmodule
`default_nettype wire

// ===== test/nearest_point_checker.sv =====
`timescale 1ns / 1ps
module nearest_point_checker
   import npk_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 busy,
   input  wire logic                 req_op,
   input  wire logic [COORD_W-1:0]   req_point_x,
   input  wire logic [COORD_W-1:0]   req_point_y,
   input  wire logic [IMAGE_W-1:0]   req_image_tag,
   input  wire logic [SOUND_W-1:0]   req_sound_tag,
   input  wire logic                 req_route_flag,
   input  wire logic [SLOT_W-1:0]    req_read_slot,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [COORD_W-1:0]   csr_wdata,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_accepted,
   input  wire logic [SLOT_W-1:0]    rsp_written_slot,
   input  wire logic [FILL_W-1:0]    rsp_fill_count,
   input  wire logic [SLOT_W-1:0]    rsp_farthest_slot,
   input  wire logic [COORD_W-1:0]   rsp_out_x,
   input  wire logic [COORD_W-1:0]   rsp_out_y,
   input  wire logic [DIST_W-1:0]    rsp_out_dist_sq,
   input  wire logic [IMAGE_W-1:0]   rsp_out_image,
   input  wire logic [SOUND_W-1:0]   rsp_out_sound,
   input  wire logic                 rsp_out_route,
   output int                        mismatches,
   output int                        outstanding
);

   localparam int TABLE_DEPTH = MAX_POINTS_DEF;

   typedef struct packed {
      logic               accepted;
      logic [SLOT_W-1:0]  written_slot;
      logic [FILL_W-1:0]  fill_count;
      logic [SLOT_W-1:0]  farthest_slot;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [DIST_W-1:0]  dist_sq;
      logic [IMAGE_W-1:0] image;
      logic [SOUND_W-1:0] sound;
      logic               route;
   } point_outcome_type;

   logic [COORD_W-1:0] center_x;
   logic [COORD_W-1:0] center_y;
   logic [COORD_W-1:0] kept_x     [TABLE_DEPTH];
   logic [COORD_W-1:0] kept_y     [TABLE_DEPTH];
   logic [DIST_W-1:0]  kept_dist  [TABLE_DEPTH];
   logic [IMAGE_W-1:0] kept_image [TABLE_DEPTH];
   logic [SOUND_W-1:0] kept_sound [TABLE_DEPTH];
   logic               kept_route [TABLE_DEPTH];
   int                 kept_count;
   logic [DIST_W-1:0]  far_dist;
   int                 far_slot;
   point_outcome_type  pending_results [$];
   point_outcome_type  fresh;
   point_outcome_type  oldest;

   task automatic report_mismatch(string what);
      mismatches++;
      $display("%0t ns mismatch: %s", $time, what);
   endtask

   task automatic compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
      end
   endtask

   task automatic keep_point(int s, logic [DIST_W-1:0] d);
      kept_x[s]     = req_point_x;
      kept_y[s]     = req_point_y;
      kept_dist[s]  = d;
      kept_image[s] = req_image_tag;
      kept_sound[s] = req_sound_tag;
      kept_route[s] = req_route_flag;
   endtask

   // Applies one command to the kept table and returns what the block must answer.
   task automatic track_nearest(output point_outcome_type res);
      logic [COORD_W-1:0] dx;
      logic [COORD_W-1:0] dy;
      logic [DIST_W-1:0]  d;
      int                 s;
      res = '0;
      if (req_op == OP_INSERT) begin
         dx = (req_point_x >= center_x) ? req_point_x - center_x : center_x - req_point_x;
         dy = (req_point_y >= center_y) ? req_point_y - center_y : center_y - req_point_y;
         d  = DIST_W'(dx) * DIST_W'(dx) + DIST_W'(dy) * DIST_W'(dy);
         if (kept_count < TABLE_DEPTH) begin
            s = kept_count;
            keep_point(s, d);
            kept_count++;
            if (d > far_dist) begin
               far_dist = d;
               far_slot = s;
            end
            res.accepted     = 1'b1;
            res.written_slot = SLOT_W'(s);
         end else if (d < far_dist) begin
            s = far_slot;
            keep_point(s, d);
            res.accepted     = 1'b1;
            res.written_slot = SLOT_W'(s);
            // rescan keeps the first slot holding the maximum
            far_dist = '0;
            for (int i = 0; i < kept_count; i++) begin
               if (kept_dist[i] > far_dist) begin
                  far_dist = kept_dist[i];
                  far_slot = i;
               end
            end
         end
      end else begin
         s = int'(req_read_slot);
         if (s < kept_count) begin
            res.x       = kept_x[s];
            res.y       = kept_y[s];
            res.dist_sq = kept_dist[s];
            res.image   = kept_image[s];
            res.sound   = kept_sound[s];
            res.route   = kept_route[s];
         end
      end
      res.fill_count    = FILL_W'(kept_count);
      res.farthest_slot = SLOT_W'(far_slot);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         center_x   = '0;
         center_y   = '0;
         kept_count = 0;
         far_dist   = '0;
         far_slot   = 0;
         mismatches = 0;
         pending_results.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_CENTER_X) begin
               center_x = csr_wdata;
            end else begin
               center_y = csr_wdata;
            end
         end
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result transfer with nothing expected");
            end else begin
               oldest = pending_results.pop_front();
               compare_field("accepted", rsp_accepted, oldest.accepted);
               compare_field("written_slot", rsp_written_slot, oldest.written_slot);
               compare_field("fill_count", rsp_fill_count, oldest.fill_count);
               compare_field("farthest_slot", rsp_farthest_slot, oldest.farthest_slot);
               compare_field("out_x", rsp_out_x, oldest.x);
               compare_field("out_y", rsp_out_y, oldest.y);
               compare_field("out_dist_sq", rsp_out_dist_sq, oldest.dist_sq);
               compare_field("out_image", rsp_out_image, oldest.image);
               compare_field("out_sound", rsp_out_sound, oldest.sound);
               compare_field("out_route", rsp_out_route, oldest.route);
            end
         end
         if (start && !busy) begin
            track_nearest(fresh);
            pending_results.push_back(fresh);
         end
      end
      outstanding <= pending_results.size();
   end

endmodule

// ===== test/nearest_point_keeper_test.sv =====
`timescale 1ns / 1ps
module nearest_point_keeper_test;
   import npk_pkg::*;

   localparam int ITEM_TARGET = 1450;
   localparam int FLOOD_ITEMS = 102;
   localparam int TAIL_CYCLES = MAX_POINTS_DEF + 16;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 start          = 1'b0;
   logic                 req_op         = OP_INSERT;
   logic [COORD_W-1:0]   req_point_x    = '0;
   logic [COORD_W-1:0]   req_point_y    = '0;
   logic [IMAGE_W-1:0]   req_image_tag  = '0;
   logic [SOUND_W-1:0]   req_sound_tag  = '0;
   logic                 req_route_flag = 1'b0;
   logic [SLOT_W-1:0]    req_read_slot  = '0;
   logic                 csr_we         = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = CSR_CENTER_X;
   logic [COORD_W-1:0]   csr_wdata      = '0;

   logic                 busy;
   logic                 rsp_valid;
   logic                 rsp_accepted;
   logic [SLOT_W-1:0]    rsp_written_slot;
   logic [FILL_W-1:0]    rsp_fill_count;
   logic [SLOT_W-1:0]    rsp_farthest_slot;
   logic [COORD_W-1:0]   rsp_out_x;
   logic [COORD_W-1:0]   rsp_out_y;
   logic [DIST_W-1:0]    rsp_out_dist_sq;
   logic [IMAGE_W-1:0]   rsp_out_image;
   logic [SOUND_W-1:0]   rsp_out_sound;
   logic                 rsp_out_route;

   int                   mismatches;
   int                   outstanding;
   int                   issued = 0;
   bit                   no_gaps = 1'b0;
   logic [COORD_W-1:0]   cx = '0;
   logic [COORD_W-1:0]   cy = '0;
   logic [COORD_W-1:0]   recent_x [8] = '{default: '0};
   logic [COORD_W-1:0]   recent_y [8] = '{default: '0};

   nearest_point_keeper u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_image_tag     (req_image_tag),
      .req_sound_tag     (req_sound_tag),
      .req_route_flag    (req_route_flag),
      .req_read_slot     (req_read_slot),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_accepted      (rsp_accepted),
      .rsp_written_slot  (rsp_written_slot),
      .rsp_fill_count    (rsp_fill_count),
      .rsp_farthest_slot (rsp_farthest_slot),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_dist_sq   (rsp_out_dist_sq),
      .rsp_out_image     (rsp_out_image),
      .rsp_out_sound     (rsp_out_sound),
      .rsp_out_route     (rsp_out_route)
   );

   nearest_point_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_point_x       (req_point_x),
      .req_point_y       (req_point_y),
      .req_image_tag     (req_image_tag),
      .req_sound_tag     (req_sound_tag),
      .req_route_flag    (req_route_flag),
      .req_read_slot     (req_read_slot),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_accepted      (rsp_accepted),
      .rsp_written_slot  (rsp_written_slot),
      .rsp_fill_count    (rsp_fill_count),
      .rsp_farthest_slot (rsp_farthest_slot),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_dist_sq   (rsp_out_dist_sq),
      .rsp_out_image     (rsp_out_image),
      .rsp_out_sound     (rsp_out_sound),
      .rsp_out_route     (rsp_out_route),
      .mismatches        (mismatches),
      .outstanding       (outstanding)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   task automatic issue_cmd(logic op, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [IMAGE_W-1:0] img, logic [SOUND_W-1:0] snd,
                            logic route, logic [SLOT_W-1:0] slot);
      int unsigned pick;
      int unsigned gap;
      req_op         <= op;
      req_point_x    <= x;
      req_point_y    <= y;
      req_image_tag  <= img;
      req_sound_tag  <= snd;
      req_route_flag <= route;
      req_read_slot  <= slot;
      start          <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      issued++;
      pick = $urandom_range(0, 99);
      if (no_gaps || pick < 55) begin
         gap = 0;
      end else if (pick < 90) begin
         gap = $urandom_range(1, 4);
      end else begin
         gap = $urandom_range(8, 60);
      end
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic insert_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      issue_cmd(OP_INSERT, x, y, IMAGE_W'($urandom), SOUND_W'($urandom),
                1'($urandom), SLOT_W'($urandom));
   endtask

   task automatic read_back(logic [SLOT_W-1:0] slot);
      issue_cmd(OP_READ, COORD_W'($urandom), COORD_W'($urandom), IMAGE_W'($urandom),
                SOUND_W'($urandom), 1'($urandom), slot);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic set_center(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      csr_we    <= 1'b1;
      csr_index <= CSR_CENTER_X;
      csr_wdata <= x;
      @(posedge clock);
      csr_index <= CSR_CENTER_Y;
      csr_wdata <= y;
      @(posedge clock);
      csr_we <= 1'b0;
      cx = x;
      cy = y;
   endtask

   function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] c,
                                                     int unsigned spread);
      return c + COORD_W'($urandom_range(0, 2 * spread)) - COORD_W'(spread);
   endfunction

   initial begin
      int unsigned        pick;
      int unsigned        spread;
      int unsigned        phase_len;
      int unsigned        idx;
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // center at reset value
      read_back('0);
      issue_cmd(OP_INSERT, '0, '0, '0, '0, 1'b0, '0);
      issue_cmd(OP_INSERT, '1, '1, '1, '1, 1'b1, '1);
      insert_point('1, '0);
      insert_point('0, '1);
      read_back(SLOT_W'(1));
      read_back(SLOT_W'(3));
      read_back(SLOT_W'(4));
      read_back('1);
      wait_idle();
      set_center('1, '1);
      insert_point('0, '0);
      insert_point('1, '1);
      read_back(SLOT_W'(5));
      read_back(SLOT_W'(6));
      wait_idle();
      set_center('0, '1);
      insert_point('0, '1);
      insert_point('1, '0);

      while (issued < ITEM_TARGET - FLOOD_ITEMS) begin
         wait_idle();
         case ($urandom_range(0, 4))
            0: set_center('0, '0);
            1: set_center('1, '1);
            2: set_center('1, '0);
            default: set_center(COORD_W'($urandom), COORD_W'($urandom));
         endcase
         no_gaps   = ($urandom_range(0, 5) == 0);
         phase_len = $urandom_range(60, 200);
         for (int k = 0; k < phase_len && issued < ITEM_TARGET - FLOOD_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 22) begin
               read_back(SLOT_W'($urandom));
            end else if (pick < 24) begin
               wait_idle();
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 45) begin
                  case ($urandom_range(0, 3))
                     0: spread = 3;
                     1: spread = 40;
                     2: spread = 4000;
                     default: spread = 300000;
                  endcase
                  px = near_coord(cx, spread);
                  py = near_coord(cy, spread);
               end else if (pick < 65) begin
                  idx = $urandom_range(0, 7);
                  px  = recent_x[idx];
                  py  = recent_y[idx];
               end else if (pick < 73) begin
                  px = $urandom_range(0, 1) ? '1 : '0;
                  py = $urandom_range(0, 1) ? '1 : '0;
               end else begin
                  px = COORD_W'($urandom);
                  py = COORD_W'($urandom);
               end
               idx           = $urandom_range(0, 7);
               recent_x[idx] = px;
               recent_y[idx] = py;
               insert_point(px, py);
            end
         end
      end

      // flood the full table with zero-distance points; afterwards nothing gets in
      wait_idle();
      set_center(COORD_W'($urandom), COORD_W'($urandom));
      no_gaps = 1'b0;
      for (int k = 0; k < 90; k++) begin
         if (k % 5 == 4) begin
            read_back(SLOT_W'($urandom));
         end else begin
            insert_point(cx, cy);
         end
      end
      for (int k = 0; k < 12; k++) begin
         if (k % 3 == 2) begin
            read_back(SLOT_W'($urandom));
         end else begin
            insert_point(near_coord(cx, 5), COORD_W'($urandom));
         end
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== nearest_point_keeper.f =====
rtl/npk_pkg.sv
rtl/npk_ram.sv
rtl/npk_ctrl.sv
rtl/npk_datapath.sv
rtl/nearest_point_keeper.sv
test/nearest_point_checker.sv
test/nearest_point_keeper_test.sv
